FILE: src/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared types and codes for the keyboard rollover tracker: event and report
// beats, the controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package hkr_pkg;

  localparam int REPORT_SLOTS = 6;

  // event modes
  localparam logic [2:0] MODE_KEY_DOWN    = 3'd0;
  localparam logic [2:0] MODE_KEY_UP      = 3'd1;
  localparam logic [2:0] MODE_RELEASE_ALL = 3'd2;
  localparam logic [2:0] MODE_BUS_RESET   = 3'd3;
  localparam logic [2:0] MODE_BUS_CONFIG  = 3'd4;

  // report status codes
  localparam logic [1:0] STATUS_SENT    = 2'd0;
  localparam logic [1:0] STATUS_NOT_CFG = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_BUS     = 2'd3;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] modifier_bits;
    logic [7:0] key_code;
  } key_item_t;

  typedef struct packed {
    logic       report_valid;
    logic [1:0] status;
    logic [7:0] report_modifiers;
    logic [7:0] slot_code_0;
    logic [7:0] slot_code_1;
    logic [7:0] slot_code_2;
    logic [7:0] slot_code_3;
    logic [7:0] slot_code_4;
    logic [7:0] slot_code_5;
    logic [2:0] held_count;
    logic       key_is_held;
  } rpt_item_t;

  typedef struct packed {
    logic       load;
    logic       mods_or;
    logic       mods_andn;
    logic       insert;
    logic       remove;
    logic       clear_keys;
    logic       set_cfg;
    logic       clr_cfg;
    logic [1:0] status;
    logic       report_valid;
  } dp_cmd_t;

  typedef struct packed {
    logic configured;
    logic hit;
    logic full;
  } dp_status_t;

endpackage

FILE: src/hkr_ctrl.sv
// ----------------------------------------------------------------------------
// hkr_ctrl
// Handshake state machine and event decode; drives the datapath commands.
// ----------------------------------------------------------------------------
module hkr_ctrl
  import hkr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       key_valid,
  output logic       key_stall,
  input  key_item_t  key_item,
  output logic       rpt_valid,
  input  logic       rpt_stall,
  input  dp_status_t dp_status,
  output dp_cmd_t    dp_cmd
);

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_FULL  = 1'b1;

  logic state;
  logic state_next;
  logic accept;
  logic code_nz;

  assign rpt_valid = (state == ST_FULL);
  assign key_stall = (state == ST_FULL) && rpt_stall;
  assign accept    = key_valid && !key_stall;
  assign code_nz   = (key_item.key_code != 8'd0);

  always_comb begin
    state_next = state;
    case (state)
      ST_EMPTY: begin
        if (accept) state_next = ST_FULL;
      end
      ST_FULL: begin
        if (!rpt_stall && !accept) state_next = ST_EMPTY;
      end
      default: state_next = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    dp_cmd        = '0;
    dp_cmd.load   = accept;
    dp_cmd.status = STATUS_BUS;
    case (key_item.mode)
      MODE_KEY_DOWN: begin
        if (!dp_status.configured) begin
          dp_cmd.status = STATUS_NOT_CFG;
        end else begin
          dp_cmd.mods_or = 1'b1;
          dp_cmd.status  = STATUS_SENT;
          if (code_nz && !dp_status.hit) begin
            if (dp_status.full) dp_cmd.status = STATUS_FULL;
            else                dp_cmd.insert = 1'b1;
          end
          dp_cmd.report_valid = (dp_cmd.status == STATUS_SENT);
        end
      end
      MODE_KEY_UP: begin
        if (!dp_status.configured) begin
          dp_cmd.status = STATUS_NOT_CFG;
        end else begin
          dp_cmd.mods_andn    = 1'b1;
          dp_cmd.remove       = code_nz && dp_status.hit;
          dp_cmd.status       = STATUS_SENT;
          dp_cmd.report_valid = 1'b1;
        end
      end
      MODE_RELEASE_ALL: begin
        dp_cmd.clear_keys = 1'b1;
        if (dp_status.configured) begin
          dp_cmd.status       = STATUS_SENT;
          dp_cmd.report_valid = 1'b1;
        end else begin
          dp_cmd.status = STATUS_NOT_CFG;
        end
      end
      MODE_BUS_RESET: begin
        dp_cmd.clear_keys = 1'b1;
        dp_cmd.clr_cfg    = 1'b1;
      end
      MODE_BUS_CONFIG: begin
        dp_cmd.clear_keys = 1'b1;
        dp_cmd.set_cfg    = 1'b1;
      end
      default: begin
        dp_cmd.status = STATUS_BUS;
      end
    endcase
  end

endmodule

FILE: src/hkr_datapath.sv
// ----------------------------------------------------------------------------
// hkr_datapath
// Key slots, modifier byte, configured flag and the registered report beat.
// ----------------------------------------------------------------------------
module hkr_datapath
  import hkr_pkg::*;
#(
  parameter int ROLLOVER_KEYS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  key_item_t  key_item,
  input  dp_cmd_t    dp_cmd,
  output dp_status_t dp_status,
  output rpt_item_t  rpt_item
);

  localparam int CNT_W = $clog2(ROLLOVER_KEYS + 1);

  logic             configured;
  logic             configured_next;
  logic [7:0]       mods;
  logic [7:0]       mods_next;
  logic [7:0]       slots      [ROLLOVER_KEYS];
  logic [7:0]       slots_next [ROLLOVER_KEYS];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+2:0] count_ext;

  logic [ROLLOVER_KEYS-1:0] hit;
  logic [ROLLOVER_KEYS-1:0] empty;
  logic [ROLLOVER_KEYS-1:0] first_empty;
  logic                     code_nz;
  logic                     held_after;
  logic [7:0]               shown [REPORT_SLOTS];

  assign code_nz = (key_item.key_code != 8'd0);

  // parallel slot compares and lowest-empty pick
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < ROLLOVER_KEYS; i++) begin
      hit[i]         = code_nz && (slots[i] == key_item.key_code);
      empty[i]       = (slots[i] == 8'd0);
      first_empty[i] = empty[i] && !seen;
      seen           = seen || empty[i];
    end
  end

  assign dp_status.configured = configured;
  assign dp_status.hit        = |hit;
  assign dp_status.full       = ~|empty;

  always_comb begin
    configured_next = configured;
    mods_next       = mods;
    count_next      = count;
    for (int i = 0; i < ROLLOVER_KEYS; i++) slots_next[i] = slots[i];

    if (dp_cmd.set_cfg) configured_next = 1'b1;
    if (dp_cmd.clr_cfg) configured_next = 1'b0;
    if (dp_cmd.mods_or)   mods_next = mods | key_item.modifier_bits;
    if (dp_cmd.mods_andn) mods_next = mods & ~key_item.modifier_bits;

    if (dp_cmd.clear_keys) begin
      mods_next  = 8'd0;
      count_next = '0;
      for (int i = 0; i < ROLLOVER_KEYS; i++) slots_next[i] = 8'd0;
    end else if (dp_cmd.insert) begin
      count_next = count + CNT_W'(1);
      for (int i = 0; i < ROLLOVER_KEYS; i++) begin
        if (first_empty[i]) slots_next[i] = key_item.key_code;
      end
    end else if (dp_cmd.remove) begin
      if (count != '0) count_next = count - CNT_W'(1);
      for (int i = 0; i < ROLLOVER_KEYS; i++) begin
        if (hit[i]) slots_next[i] = 8'd0;
      end
    end
  end

  // a held code sits in one slot only, so removal empties it
  assign held_after = code_nz &&
                      ((dp_status.hit && !dp_cmd.remove && !dp_cmd.clear_keys) ||
                       dp_cmd.insert);

  assign count_ext = (CNT_W + 3)'(count_next);

  for (genvar j = 0; j < REPORT_SLOTS; j++) begin : g_shown
    if (j < ROLLOVER_KEYS) begin : g_used
      assign shown[j] = slots_next[j];
    end else begin : g_unused
      assign shown[j] = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      configured <= 1'b0;
      mods       <= 8'd0;
      count      <= '0;
      for (int i = 0; i < ROLLOVER_KEYS; i++) slots[i] <= 8'd0;
    end else if (dp_cmd.load) begin
      configured <= configured_next;
      mods       <= mods_next;
      count      <= count_next;
      for (int i = 0; i < ROLLOVER_KEYS; i++) slots[i] <= slots_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      rpt_item.report_valid     <= dp_cmd.report_valid;
      rpt_item.status           <= dp_cmd.status;
      rpt_item.report_modifiers <= mods_next;
      rpt_item.slot_code_0      <= shown[0];
      rpt_item.slot_code_1      <= shown[1];
      rpt_item.slot_code_2      <= shown[2];
      rpt_item.slot_code_3      <= shown[3];
      rpt_item.slot_code_4      <= shown[4];
      rpt_item.slot_code_5      <= shown[5];
      rpt_item.held_count       <= (count_ext > (CNT_W + 3)'(7)) ? 3'd7 : count_ext[2:0];
      rpt_item.key_is_held      <= held_after;
    end
  end

endmodule

FILE: src/hid_keyboard_rollover_tracker.sv
// ----------------------------------------------------------------------------
// hid_keyboard_rollover_tracker
// Keyboard state tracker producing a boot-style 6-key rollover report image.
// ----------------------------------------------------------------------------
// usage
//   key channel: one beat per event (key down, key up, release all, bus reset
//   or disconnect, bus configured) with modifier bits and a keycode.
//   rpt channel: exactly one beat per event, carrying the report image after
//   the event, a status code, the held key count and a key-held flag.
//   latency: the result beat is valid the cycle after the event is accepted.
//   throughput: one event per cycle; the slot compares, the lowest-empty pick
//   and the slot update all settle combinationally before the output
//   register, so a new event is taken every cycle while rpt is not stalled.
//   stall: while a result beat waits under rpt_stall, key_stall is raised;
//   when the receiver takes the beat, a new event is accepted in that same
//   cycle.
//   reset: bus not configured, modifiers and all key slots cleared, no
//   result pending.
// ----------------------------------------------------------------------------
module hid_keyboard_rollover_tracker
  import hkr_pkg::*;
#(
  parameter int ROLLOVER_KEYS = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      key_valid,
  output logic      key_stall,
  input  key_item_t key_item,
  output logic      rpt_valid,
  input  logic      rpt_stall,
  output rpt_item_t rpt_item
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  hkr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_item  (key_item),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  hkr_datapath #(
    .ROLLOVER_KEYS (ROLLOVER_KEYS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .key_item  (key_item),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .rpt_item  (rpt_item)
  );

  // an accepted event always shows up as a result beat next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (key_valid && !key_stall) |=> rpt_valid)
    else $error("accepted event produced no result beat");

  // a report is only flagged for the sent status
  a_report_status: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && rpt_item.report_valid) |-> (rpt_item.status == STATUS_SENT))
    else $error("report flagged with non-sent status");

  // held count never exceeds the slot count
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (int'(rpt_item.held_count) <= ROLLOVER_KEYS))
    else $error("held count exceeds rollover slots");

  // bus events never carry a report
  a_bus_no_report: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && rpt_item.status == STATUS_BUS) |-> !rpt_item.report_valid)
    else $error("bus event produced a report");

endmodule
